// ===== hdl/nmea_pkg.sv =====
// Package: shared types, constants and helper functions of the NMEA sentence checker.
`default_nettype none
package nmea_pkg;

    localparam int MAX_LINE_DEF = 256;
    localparam int LINE_LEN_W   = 9;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_G      = 8'h47;

    localparam logic [23:0] HEAD_GSV = 24'h475356;
    localparam logic [23:0] HEAD_RMC = 24'h524D43;
    localparam logic [23:0] HEAD_ZDA = 24'h5A4441;

    localparam logic [3:0] MAX_COMMAS = 4'd13;
    localparam logic [3:0] MIN_GSV    = 4'd3;
    localparam logic [3:0] MIN_RMC    = 4'd13;
    localparam logic [3:0] MIN_ZDA    = 4'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SUM   = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GSV   = 2'd1,
        KIND_RMC   = 2'd2,
        KIND_ZDA   = 2'd3
    } kind_t;

    typedef struct packed {
        status_t                 status;
        kind_t                   sentence_kind;
        logic [7:0]              talker_letter;
        logic [3:0]              field_count;
        logic [LINE_LEN_W-1:0]   line_length;
        logic [7:0]              computed_sum;
    } result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        return (nib > 4'd9) ? ({4'h0, nib} + 8'h37) : ({4'h0, nib} + 8'h30);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/nmea_line_state.sv =====
// Line state: running checksum, head and tail characters, counters, and result formation.
`default_nettype none
module nmea_line_state #(
    parameter int MAX_LINE = nmea_pkg::MAX_LINE_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                step,
    input  wire  [7:0]         rx_byte,
    output logic               emit,
    output nmea_pkg::result_t  result
);
    import nmea_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE + 1);

    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       tail_reg [3];
    logic [7:0]       tail_next [3];
    logic [7:0]       head_reg [6];
    logic [7:0]       head_next [6];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       comma_reg, comma_next;
    logic             ovf_reg, ovf_next;

    logic             printable;
    logic             malformed;
    logic             sum_match;
    status_t          status;
    kind_t            kind;
    logic [23:0]      head_tag;

    assign printable = rx_byte >= CHAR_SPACE;

    always_comb begin
        xor_next   = xor_reg;
        tail_next  = tail_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        comma_next = comma_reg;
        ovf_next   = ovf_reg;
        if (step) begin
            if (printable) begin
                if (cnt_reg >= CNT_W'(MAX_LINE)) begin
                    ovf_next = 1'b1;
                end else begin
                    for (int i = 0; i < 6; i++) begin
                        if (cnt_reg == CNT_W'(i)) begin
                            head_next[i] = rx_byte;
                        end
                    end
                    if (cnt_reg >= CNT_W'(3)) begin
                        if (cnt_reg >= CNT_W'(4)) begin
                            xor_next = xor_reg ^ tail_reg[0];
                        end
                        if (tail_reg[0] == CHAR_COMMA && comma_reg < MAX_COMMAS) begin
                            comma_next = comma_reg + 4'd1;
                        end
                    end
                    tail_next[0] = tail_reg[1];
                    tail_next[1] = tail_reg[2];
                    tail_next[2] = rx_byte;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end else begin
                xor_next   = '0;
                tail_next  = '{default: '0};
                head_next  = '{default: '0};
                cnt_next   = '0;
                comma_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xor_reg   <= '0;
            tail_reg  <= '{default: '0};
            head_reg  <= '{default: '0};
            cnt_reg   <= '0;
            comma_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            xor_reg   <= xor_next;
            tail_reg  <= tail_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            comma_reg <= comma_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign emit = !printable && (cnt_reg != '0 || ovf_reg);

    assign malformed = cnt_reg < CNT_W'(4) || head_reg[0] != CHAR_DOLLAR ||
                       tail_reg[0] != CHAR_STAR || !is_hex(tail_reg[1]) ||
                       !is_hex(tail_reg[2]);
    assign sum_match = hex_upper(xor_reg[7:4]) == tail_reg[1] &&
                       hex_upper(xor_reg[3:0]) == tail_reg[2];
    assign head_tag  = {head_reg[3], head_reg[4], head_reg[5]};

    always_comb begin
        if (ovf_reg) begin
            status = ST_OVERFLOW;
        end else if (malformed) begin
            status = ST_MALFORMED;
        end else if (!sum_match) begin
            status = ST_BAD_SUM;
        end else begin
            status = ST_OK;
        end
        kind = KIND_OTHER;
        if (status == ST_OK && cnt_reg >= CNT_W'(9) && head_reg[1] == CHAR_G) begin
            if (head_tag == HEAD_GSV && comma_reg >= MIN_GSV) begin
                kind = KIND_GSV;
            end else if (head_tag == HEAD_RMC && comma_reg >= MIN_RMC) begin
                kind = KIND_RMC;
            end else if (head_tag == HEAD_ZDA && comma_reg >= MIN_ZDA) begin
                kind = KIND_ZDA;
            end
        end
        result.status        = status;
        result.sentence_kind = kind;
        result.talker_letter = head_reg[2];
        result.field_count   = comma_reg;
        result.line_length   = LINE_LEN_W'(cnt_reg);
        result.computed_sum  = xor_reg;
    end

endmodule
`default_nettype wire

// ===== hdl/nmea_out_reg.sv =====
// Result register: holds one finished line result until the downstream side takes it.
`default_nettype none
module nmea_out_reg (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                load,
    input  nmea_pkg::result_t  load_data,
    input  wire                m_ready,
    output logic               m_valid,
    output logic               can_load,
    output nmea_pkg::result_t  data
);
    import nmea_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign data    = data_reg;

endmodule
`default_nettype wire

// ===== hdl/nmea_sentence_checker.sv =====
// Top level: input register, line state and result register of the NMEA sentence checker.
//
// Accepts one received character per cycle on the s_ channel and gives one result on the
// m_ channel for each non-empty line ended by a control character (below 0x20). A
// character waits in the input register while the line logic forms the result, which is
// then loaded into the result register; throughput is one character per cycle while the
// input does not stall, as the running XOR and counters update for each character.
// Input stalls only while the result register is full and not being taken and the waiting
// character ends a line. Lines longer than MAX_LINE characters report overflow.
`default_nettype none
module nmea_sentence_checker #(
    parameter int MAX_LINE = nmea_pkg::MAX_LINE_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire  [7:0]   s_rx_byte,
    output logic         m_valid,
    input  wire          m_ready,
    output logic [1:0]   m_status,
    output logic [1:0]   m_sentence_kind,
    output logic [7:0]   m_talker_letter,
    output logic [3:0]   m_field_count,
    output logic [8:0]   m_line_length,
    output logic [7:0]   m_computed_sum
);
    import nmea_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       emit;
    logic       can_load;
    result_t    line_result;
    result_t    out_data;

    assign advance = in_valid_reg && (!emit || can_load);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    nmea_line_state #(
        .MAX_LINE (MAX_LINE)
    ) u_line_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (line_result)
    );

    nmea_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && emit),
        .load_data (line_result),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .can_load  (can_load),
        .data      (out_data)
    );

    assign m_status        = out_data.status;
    assign m_sentence_kind = out_data.sentence_kind;
    assign m_talker_letter = out_data.talker_letter;
    assign m_field_count   = out_data.field_count;
    assign m_line_length   = out_data.line_length;
    assign m_computed_sum  = out_data.computed_sum;

endmodule
`default_nettype wire
